>>> rtl/bms_pkg.sv
// Shared constants, types and tables of the Box-Muller sampler.
`default_nettype none
package bms_pkg;

	localparam int UNIFORM_BITS = 32;
	localparam int FRAC_BITS = 24;

	localparam int U_W = 32;
	localparam int LOG_ITERS = 30;
	localparam int LNQ_W = 35;
	localparam int VAR_W = 28;
	localparam int SQ_W = 64 - (28 - FRAC_BITS);
	localparam int ROOT_W = SQ_W / 2;
	localparam int HORNER = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [U_W-1:0] UMASK = U_W'((64'd1 << UNIFORM_BITS) - 64'd1);
	localparam logic [28:0] LN2_Q29 = 29'd372130559;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	localparam logic [30:0] COS_COEF [8] = '{
		31'd1073741824, 31'd1324675879, 31'd272375560, 31'd22401992,
		31'd987048, 31'd27080, 31'd506, 31'd7
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEAN_OFFSET = 2'd0,
		CFG_VARIANCE    = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] mean_offset;
		logic [VAR_W-1:0]   variance;
	} cfg_t;

	typedef struct packed {
		logic [LNQ_W-1:0] lnq;
		logic [U_W-1:0]   u2;
	} log_res_t;

	typedef struct packed {
		logic [ROOT_W-1:0] radius;
		logic [U_W-1:0]    u2;
	} rad_res_t;

endpackage
`default_nettype wire

>>> rtl/bms_in_if.sv
// Request channel carrying a pair of uniform values.
`default_nettype none
interface bms_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] uniform_radius;
	logic [31:0] uniform_angle;

	modport source(output valid, output uniform_radius, output uniform_angle, input ready);
	modport sink(input valid, input uniform_radius, input uniform_angle, output ready);
endinterface
`default_nettype wire

>>> rtl/bms_out_if.sv
// Result channel carrying one Gaussian sample.
`default_nettype none
interface bms_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample;
	logic        saturated;

	modport source(output valid, output sample, output saturated, input ready);
	modport sink(input valid, input sample, input saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/bms_log.sv
// Pipelined -ln(u1) in Q.30: normalize, bitwise log2 by squaring, scale by ln2.
`default_nettype none
module bms_log (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic [31:0]         u1,
	input  logic [31:0]         u2,
	output logic                vout,
	output bms_pkg::log_res_t   dout
);
	import bms_pkg::*;

	logic [U_W-1:0] u1m;
	logic [U_W-1:0] u1c;
	logic [4:0]     k;
	logic [U_W-1:0] x0;
	logic [5:0]     e0;

	logic           sq_v_s   [LOG_ITERS+1];
	logic [31:0]    x_s      [LOG_ITERS+1];
	logic [29:0]    frac_s   [LOG_ITERS+1];
	logic [5:0]     e_s      [LOG_ITERS+1];
	logic [31:0]    u2_s     [LOG_ITERS+1];

	logic [63:0]    sqp  [LOG_ITERS];
	logic [31:0]    nx   [LOG_ITERS];
	logic           nb   [LOG_ITERS];

	logic           v_s32, v_s33, v_s34;
	logic [35:0]    nl_s32;
	logic [31:0]    u2_s32, u2_s33, u2_s34;
	logic [46:0]    plo_s33, phi_s33;
	logic [LNQ_W-1:0] lnq_s34;
	logic [64:0]    lsum;

	// find the leading one and shift it to bit 31
	always_comb begin
		u1m = u1 & UMASK;
		u1c = (u1m == '0) ? U_W'(1) : u1m;
		k = '0;
		for (int i = 0; i < 32; i++) begin
			if (u1c[i]) k = 5'(i);
		end
		x0 = u1c << (5'd31 - k);
		e0 = 6'(UNIFORM_BITS) - {1'b0, k};
	end

	always_comb begin
		for (int i = 0; i < LOG_ITERS; i++) begin
			sqp[i] = 64'(x_s[i]) * 64'(x_s[i]);
			nb[i] = sqp[i][63];
			nx[i] = sqp[i][63] ? sqp[i][63:32] : sqp[i][62:31];
		end
		lsum = {phi_s33, 18'b0} + {18'b0, plo_s33};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LOG_ITERS; i++) sq_v_s[i] <= 1'b0;
			v_s32 <= 1'b0;
			v_s33 <= 1'b0;
			v_s34 <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= vin;
			for (int i = 0; i < LOG_ITERS; i++) sq_v_s[i+1] <= sq_v_s[i];
			v_s32 <= sq_v_s[LOG_ITERS];
			v_s33 <= v_s32;
			v_s34 <= v_s33;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x0;
			frac_s[0] <= '0;
			e_s[0] <= e0;
			u2_s[0] <= u2;
			for (int i = 0; i < LOG_ITERS; i++) begin
				x_s[i+1] <= nx[i];
				frac_s[i+1] <= {frac_s[i][28:0], nb[i]};
				e_s[i+1] <= e_s[i];
				u2_s[i+1] <= u2_s[i];
			end
			nl_s32 <= {e_s[LOG_ITERS], 30'b0} - {6'b0, frac_s[LOG_ITERS]};
			u2_s32 <= u2_s[LOG_ITERS];
			plo_s33 <= 47'(nl_s32[17:0]) * 47'(LN2_Q29);
			phi_s33 <= 47'(nl_s32[35:18]) * 47'(LN2_Q29);
			u2_s33 <= u2_s32;
			lnq_s34 <= lsum[63:29];
			u2_s34 <= u2_s33;
		end
	end

	assign vout = v_s34;
	assign dout = '{lnq: lnq_s34, u2: u2_s34};

endmodule
`default_nettype wire

>>> rtl/bms_sqrt.sv
// Pipelined radius: scale by 2*variance, then one root bit per stage.
`default_nettype none
module bms_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [27:0]          variance,
	input  logic                 vin,
	input  bms_pkg::log_res_t    din,
	output logic                 vout,
	output bms_pkg::rad_res_t    dout
);
	import bms_pkg::*;

	logic              v_s1;
	logic [45:0]       qlo_s1;
	logic [44:0]       qhi_s1;
	logic [31:0]       u2_s1;
	logic [62:0]       qsum;
	logic [63:0]       r2;

	logic              rt_v_s   [ROOT_W+1];
	logic [SQ_W-1:0]   rem_s    [ROOT_W+1];
	logic [SQ_W-1:0]   res_s    [ROOT_W+1];
	logic [31:0]       rt_u2_s  [ROOT_W+1];

	logic [SQ_W-1:0]   trial [ROOT_W];
	logic [SQ_W-1:0]   nrem  [ROOT_W];
	logic [SQ_W-1:0]   nres  [ROOT_W];

	always_comb begin
		qsum = {qhi_s1, 18'b0} + {17'b0, qlo_s1};
		r2 = {qsum, 1'b0};
		for (int i = 0; i < ROOT_W; i++) begin
			trial[i] = res_s[i] + (SQ_W'(1) << (SQ_W - 2 - 2 * i));
			if (rem_s[i] >= trial[i]) begin
				nrem[i] = rem_s[i] - trial[i];
				nres[i] = (res_s[i] >> 1) + (SQ_W'(1) << (SQ_W - 2 - 2 * i));
			end else begin
				nrem[i] = rem_s[i];
				nres[i] = res_s[i] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i <= ROOT_W; i++) rt_v_s[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			rt_v_s[0] <= v_s1;
			for (int i = 0; i < ROOT_W; i++) rt_v_s[i+1] <= rt_v_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qlo_s1 <= 46'(din.lnq[17:0]) * 46'(variance);
			qhi_s1 <= 45'(din.lnq[LNQ_W-1:18]) * 45'(variance);
			u2_s1 <= din.u2;
			rem_s[0] <= r2[63:64-SQ_W];
			res_s[0] <= '0;
			rt_u2_s[0] <= u2_s1;
			for (int i = 0; i < ROOT_W; i++) begin
				rem_s[i+1] <= nrem[i];
				res_s[i+1] <= nres[i];
				rt_u2_s[i+1] <= rt_u2_s[i];
			end
		end
	end

	assign vout = rt_v_s[ROOT_W];
	assign dout = '{radius: res_s[ROOT_W][ROOT_W-1:0], u2: rt_u2_s[ROOT_W]};

endmodule
`default_nettype wire

>>> rtl/bms_cos.sv
// Pipelined quarter-wave cosine by Horner steps, radius product, mean add and clip.
`default_nettype none
module bms_cos (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [31:0]   mean_offset,
	input  logic                 vin,
	input  bms_pkg::rad_res_t    din,
	output logic                 vout,
	output logic [31:0]          sample,
	output logic                 saturated
);
	import bms_pkg::*;

	logic [31:0]       phase;
	logic [30:0]       t0;

	logic              v_s1;
	logic [30:0]       t_s1;
	logic              neg_s1;
	logic [ROOT_W-1:0] rad_s1;
	logic [61:0]       tt;

	logic              h_v_s   [HORNER+1];
	logic [30:0]       z_s     [HORNER+1];
	logic [30:0]       acc_s   [HORNER+1];
	logic              h_neg_s [HORNER+1];
	logic [ROOT_W-1:0] h_rad_s [HORNER+1];

	logic [61:0]       hp   [HORNER];
	logic [31:0]       hsh  [HORNER];
	logic [30:0]       nacc [HORNER];

	logic              v_s10;
	logic [30:0]       mag_s10;
	logic              neg_s10;
	logic [61:0]       mp;

	logic              v_s11;
	logic [31:0]       sample_s11;
	logic              sat_s11;
	logic signed [32:0] sum;

	always_comb begin
		phase = din.u2 << (32 - UNIFORM_BITS);
		t0 = phase[30] ? (ONE_Q30 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
		tt = 62'(t_s1) * 62'(t_s1);
		for (int j = 0; j < HORNER; j++) begin
			hp[j] = 62'(z_s[j]) * 62'(acc_s[j]);
			hsh[j] = hp[j][61:30];
			// hold at zero where the polynomial would dip below
			nacc[j] = ({1'b0, COS_COEF[HORNER-1-j]} > hsh[j]) ?
				31'({1'b0, COS_COEF[HORNER-1-j]} - hsh[j]) : '0;
		end
		mp = 62'(h_rad_s[HORNER]) * 62'((acc_s[HORNER] > ONE_Q30) ? ONE_Q30 : acc_s[HORNER]);
		sum = neg_s10 ? (33'(mean_offset) - 33'({2'b0, mag_s10})) :
			(33'(mean_offset) + 33'({2'b0, mag_s10}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int j = 0; j <= HORNER; j++) h_v_s[j] <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			h_v_s[0] <= v_s1;
			for (int j = 0; j < HORNER; j++) h_v_s[j+1] <= h_v_s[j];
			v_s10 <= h_v_s[HORNER];
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t0;
			neg_s1 <= phase[31] ^ phase[30];
			rad_s1 <= din.radius;
			z_s[0] <= tt[60:30];
			acc_s[0] <= COS_COEF[HORNER];
			h_neg_s[0] <= neg_s1;
			h_rad_s[0] <= rad_s1;
			for (int j = 0; j < HORNER; j++) begin
				z_s[j+1] <= z_s[j];
				acc_s[j+1] <= nacc[j];
				h_neg_s[j+1] <= h_neg_s[j];
				h_rad_s[j+1] <= h_rad_s[j];
			end
			mag_s10 <= 31'((mp + 62'd1073741824) >> 31);
			neg_s10 <= h_neg_s[HORNER];
			sat_s11 <= sum[32] ^ sum[31];
			if (sum[32] ^ sum[31]) sample_s11 <= sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else sample_s11 <= sum[31:0];
		end
	end

	assign vout = v_s11;
	assign sample = sample_s11;
	assign saturated = sat_s11;

endmodule
`default_nettype wire

>>> rtl/box_muller_gaussian_sampler.sv
// Box-Muller Gaussian sampler: takes a pair of 32-bit uniforms (u1, u2) and returns
// mean_offset + sqrt(-2*variance*ln(u1/2^32))*cos(2*pi*u2/2^32) in signed Q8.24,
// clipped to 32 bits with a saturated flag. One request is taken every clock cycle;
// each result leaves in request order, registered through the 30 squaring stages of
// the log2 unit and the 30 bit stages of the square root. A request with
// both uniforms zero produces no result; u1 alone zero is treated as one LSB. When
// the result side stalls, the whole pipeline holds and request ready drops.
// Write mean_offset (index 0) and variance (index 1) only while the pipeline is empty.
`default_nettype none
module box_muller_gaussian_sampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [bms_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [bms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	bms_in_if.sink                            draw,
	bms_out_if.source                         result
);
	import bms_pkg::*;

	cfg_t       cfg_q;
	logic       en;
	logic       vin;
	logic       log_v;
	log_res_t   log_d;
	logic       rad_v;
	rad_res_t   rad_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_offset <= 32'sd16777216;
			cfg_q.variance <= 28'd838861;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_MEAN_OFFSET: cfg_q.mean_offset <= cfg_wdata;
				CFG_VARIANCE:    cfg_q.variance <= cfg_wdata[VAR_W-1:0];
				default: ;
			endcase
		end
	end

	// advance whenever the output register is empty or being drained
	assign en = !result.valid || result.ready;
	assign draw.ready = en;
	// drop a request whose uniforms are both zero
	assign vin = draw.valid &&
		!(((draw.uniform_radius & UMASK) == '0) && ((draw.uniform_angle & UMASK) == '0));

	bms_log u_log (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(vin),
		.u1(draw.uniform_radius), .u2(draw.uniform_angle & UMASK),
		.vout(log_v), .dout(log_d)
	);

	bms_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .variance(cfg_q.variance),
		.vin(log_v), .din(log_d), .vout(rad_v), .dout(rad_d)
	);

	bms_cos u_cos (
		.clk(clk), .arst_n(arst_n), .en(en), .mean_offset(cfg_q.mean_offset),
		.vin(rad_v), .din(rad_d), .vout(result.valid),
		.sample(result.sample), .saturated(result.saturated)
	);

`ifndef SYNTHESIS
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |->
		result.sample == 32'h7FFF_FFFF || result.sample == 32'h8000_0000)
		else $error("saturated sample not at a range limit");

	a_var_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen && cfg_idx == CFG_VARIANCE |=>
		cfg_q.variance == $past(cfg_wdata[VAR_W-1:0]))
		else $error("variance write lost");

	a_mean_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen && cfg_idx == CFG_MEAN_OFFSET |=>
		cfg_q.mean_offset == $past(cfg_wdata))
		else $error("mean write lost");

	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !draw.ready)
		else $error("request taken while the pipeline is stalled");
`endif

endmodule
`default_nettype wire

>>> sim/tb_box_muller_gaussian_sampler.sv
// Self-checking testbench of the Box-Muller Gaussian sampler.
`default_nettype none
module tb_box_muller_gaussian_sampler;
	timeunit 1ns;
	timeprecision 1ps;
	import bms_pkg::*;

	localparam int LATENCY = 77;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [31:0] sample;
		logic        saturated;
	} gauss_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	bms_in_if draw ();
	bms_out_if result ();

	box_muller_gaussian_sampler dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .draw(draw.sink), .result(result.sink)
	);

	always #1 clk = ~clk;

	logic [31:0] mean_reg;
	logic [27:0] var_reg;
	gauss_t expected_samples[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycles = 0;

	initial begin
		draw.valid = 1'b0;
		draw.uniform_radius = '0;
		draw.uniform_angle = '0;
		result.ready = 1'b0;
	end

	function automatic logic [63:0] floor_sub(logic [63:0] a, logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic logic [63:0] quarter_wave(logic [63:0] t);
		logic [63:0] z, acc;
		z = (t * t) >> 30;
		acc = COS_COEF[7];
		for (int n = 6; n >= 0; n--)
			acc = floor_sub(COS_COEF[n], (z * acc) >> 30);
		if (acc > ONE_Q30)
			acc = ONE_Q30;
		return acc;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] minus_log2(logic [31:0] u);
		int k;
		logic [63:0] x, frac;
		k = 31;
		frac = 0;
		while (k > 0 && u[k] == 1'b0)
			k--;
		x = 64'(u) << (31 - k);
		for (int i = 0; i < 30; i++) begin
			x = (x * x) >> 31;
			frac <<= 1;
			if (x >= (64'd1 << 32)) begin
				frac |= 1;
				x >>= 1;
			end
		end
		return (64'(UNIFORM_BITS - k) << 30) - frac;
	endfunction

	function automatic bit gaussian_of(logic [31:0] u1, logic [31:0] u2, output gauss_t g);
		logic [63:0] lnq, r2, radius, cmag, mag, frac_part;
		logic [1:0] quad;
		logic neg;
		longint mean, sum;
		u1 &= UMASK;
		u2 &= UMASK;
		if (u1 == 0 && u2 == 0)
			return 1'b0;
		if (u1 == 0)
			u1 = 1;
		lnq = (minus_log2(u1) * LN2_Q29) >> 29;
		r2 = lnq * 64'(var_reg) * 2;
		radius = root_floor(r2 >> (28 - FRAC_BITS));
		quad = u2[31:30];
		frac_part = 64'(u2[29:0]);
		if (quad == 0 || quad == 2)
			cmag = quarter_wave(frac_part);
		else
			cmag = quarter_wave(ONE_Q30 - frac_part);
		neg = (quad == 1 || quad == 2);
		mag = (radius * cmag + (64'd1 << 30)) >> 31;
		mean = longint'($signed(mean_reg));
		sum = neg ? mean - longint'(mag) : mean + longint'(mag);
		g.saturated = 1'b0;
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
			g.saturated = 1'b1;
		end else if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
			g.saturated = 1'b1;
		end
		g.sample = sum[31:0];
		return 1'b1;
	endfunction

	// Receiver: stall at random and check each accepted result.
	always @(posedge clk) begin
		gauss_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL box_muller_gaussian_sampler");
			$finish;
		end
		if (arst_n && result.valid && result.ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample: unexpected result %h", result.sample);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				if (result.sample !== want.sample) begin
					$error("sample: expected %h actual %h", want.sample, result.sample);
					errors++;
				end
				if (result.saturated !== want.saturated) begin
					$error("saturated: expected %b actual %b", want.saturated,
						result.saturated);
					errors++;
				end
			end
		end
		result.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Leave valid high after the handshake; idle draws or drain() lower it.
	task automatic send_pair(logic [31:0] u1, logic [31:0] u2);
		gauss_t g;
		while ($urandom_range(99) < send_idle_pct) begin
			draw.valid <= 1'b0;
			@(posedge clk);
		end
		draw.valid <= 1'b1;
		draw.uniform_radius <= u1;
		draw.uniform_angle <= u2;
		@(posedge clk);
		while (!draw.ready)
			@(posedge clk);
		if (gaussian_of(u1, u2, g))
			expected_samples.push_back(g);
	endtask

	task automatic drain();
		draw.valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		if (idx == CFG_MEAN_OFFSET)
			mean_reg = value;
		else
			var_reg = value[27:0];
	endtask

	task automatic test_directed();
		logic [31:0] edges[6] = '{32'h0, 32'h1, 32'h4000_0000, 32'h8000_0000,
			32'hC000_0000, 32'hFFFF_FFFF};
		send_pair(32'h0, 32'h0);
		send_pair(32'h0, 32'h1234_5678);
		send_pair(32'h0, 32'h0);
		foreach (edges[i])
			send_pair(edges[(i + 1) % 6], edges[i]);
		send_pair(32'h1, 32'h3FFF_FFFF);
		send_pair(32'h1, 32'h4000_0001);
		send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_pair(32'h0000_0001, 32'hBFFF_FFFF);
		send_pair(32'h8000_0000, 32'h0000_0000);
		drain();
	endtask

	// Reach saturation on both sides with extreme settings.
	task automatic test_saturation();
		write_reg(CFG_MEAN_OFFSET, 32'h7FFF_0000);
		write_reg(CFG_VARIANCE, 32'hFFFF_FFFF);
		send_pair(32'h1, 32'h0);
		send_pair(32'h1, 32'h8000_0000);
		send_pair(32'h0, 32'h4000_0000);
		drain();
		write_reg(CFG_MEAN_OFFSET, 32'h8000_0000);
		send_pair(32'h1, 32'h8000_0000);
		send_pair(32'h1, 32'h0);
		drain();
		write_reg(CFG_VARIANCE, 32'h0);
		write_reg(CFG_MEAN_OFFSET, 32'h7FFF_FFFF);
		send_pair(32'h1, 32'h0);
		send_pair(32'h1234, 32'h9999_9999);
		drain();
	endtask

	task automatic test_random(int count);
		logic [31:0] u1, u2;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: u1 = $urandom_range(255);
				1: u1 = 32'hFFFF_FFFF - $urandom_range(255);
				default: u1 = $urandom;
			endcase
			case ($urandom_range(9))
				0: u2 = {2'($urandom_range(3)), 30'h0} + $urandom_range(7);
				1: u2 = {2'($urandom_range(3)), 30'h3FFF_FFFF} - $urandom_range(7);
				2: u2 = (u1 == 0) ? 32'h0 : $urandom;
				default: u2 = $urandom;
			endcase
			send_pair(u1, u2);
		end
		drain();
	endtask

	task automatic random_config();
		write_reg(CFG_MEAN_OFFSET, $urandom);
		write_reg(CFG_VARIANCE, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
	endtask

	initial begin
		mean_reg = 32'd16777216;
		var_reg = 28'd838861;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 27;
		recv_idle_pct = 68;
		test_directed();
		test_saturation();
		random_config();
		test_random(550);
		send_idle_pct = 68;
		recv_idle_pct = 27;
		random_config();
		test_random(550);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_MEAN_OFFSET, 32'd16777216);
		write_reg(CFG_VARIANCE, 32'd838861);
		test_random(600);
		if (errors == 0)
			$display("PASS box_muller_gaussian_sampler");
		else
			$display("FAIL box_muller_gaussian_sampler");
		$finish;
	end
endmodule
`default_nettype wire

>>> box_muller_gaussian_sampler.f
rtl/bms_pkg.sv
rtl/bms_in_if.sv
rtl/bms_out_if.sv
rtl/bms_log.sv
rtl/bms_sqrt.sv
rtl/bms_cos.sv
rtl/box_muller_gaussian_sampler.sv
sim/tb_box_muller_gaussian_sampler.sv
